// ===== rtl/core/box_average_downsampler_macros.svh =====
// Assertion helpers for the box average downsampler.
`ifndef BOX_AVERAGE_DOWNSAMPLER_MACROS_SVH
`define BOX_AVERAGE_DOWNSAMPLER_MACROS_SVH

`ifndef ASSERT_OFF
`define BAVG_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`define BAVG_ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error(msg);
`else
`define BAVG_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define BAVG_ASSERT_NEVER(label, clk, rstn, cond, msg)
`endif

`endif

// ===== rtl/core/bavg_pkg.sv =====
package bavg_pkg;

    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 11;
    localparam int STEP_FIELD_W = 5;
    localparam int SIZE_FIELD_W = 11;

    localparam logic [CFG_INDEX_W-1:0] CFG_USTEP    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_VSTEP    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUT_COLS = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUT_ROWS = 2'd3;

    // what the front knows about a finished row piece
    typedef struct packed {
        logic first_row;  // first source row of the block row: overwrite column sum
        logic emit;       // last source row: block is complete, produce a mean
        logic fin;        // last block of the frame
    } piece_ctl_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_ACC,
        BK_ABS,
        BK_DIV,
        BK_OUT
    } back_state_t;

    typedef struct packed {
        logic pop;
        logic out_load;
    } back_status_t;

endpackage

// ===== rtl/core/bavg_ram.sv =====
module bavg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/bavg_fifo.sv =====
module bavg_fifo #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot[wr_ptr_reg] <= push_data;
        end
    end

    assign head  = slot[rd_ptr_reg];
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

endmodule

// ===== rtl/core/bavg_front.sv =====
module bavg_front #(
    parameter int PIXEL_BITS = 24,
    parameter int MAX_STEP   = 16,
    parameter int MAX_COLS   = 1024
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          restart,
    input  logic                                          in_valid,
    input  logic                                          in_ready,
    input  logic [PIXEL_BITS-1:0]                         pixel,
    input  logic [$clog2(MAX_STEP+1)-1:0]                 ustep,
    input  logic [$clog2(MAX_STEP+1)-1:0]                 vstep,
    input  logic [$clog2(MAX_COLS+1)-1:0]                 out_cols,
    input  logic [$clog2(MAX_COLS+1)-1:0]                 out_rows,
    output logic                                          push,
    output logic [PIXEL_BITS+$clog2(MAX_STEP)-1:0]        push_sum,
    output logic [(MAX_COLS > 1 ? $clog2(MAX_COLS) : 1)-1:0] push_col,
    output bavg_pkg::piece_ctl_t                          push_ctl
);

    localparam int STEP_W = $clog2(MAX_STEP + 1);
    localparam int COL_W  = $clog2(MAX_COLS + 1);
    localparam int ADDR_W = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;
    localparam int PW     = PIXEL_BITS + $clog2(MAX_STEP);

    logic signed [PW-1:0]  row_partial_reg, row_partial_next;
    logic [STEP_W-1:0]     sub_col_reg, sub_col_next;
    logic [STEP_W-1:0]     sub_row_reg, sub_row_next;
    logic [COL_W-1:0]      block_col_reg, block_col_next;
    logic [COL_W-1:0]      block_row_reg, block_row_next;

    logic                  accept;
    logic signed [PW-1:0]  piece_sum;
    logic [STEP_W:0]       sub_col_inc, sub_row_inc;
    logic [COL_W:0]        block_col_inc, block_row_inc;
    logic                  piece_done, row_end, last_sub_row, last_block_row;

    assign accept        = in_valid && in_ready;
    assign piece_sum     = row_partial_reg + PW'($signed(pixel));
    assign sub_col_inc   = {1'b0, sub_col_reg} + 1'b1;
    assign sub_row_inc   = {1'b0, sub_row_reg} + 1'b1;
    assign block_col_inc = {1'b0, block_col_reg} + 1'b1;
    assign block_row_inc = {1'b0, block_row_reg} + 1'b1;

    assign piece_done     = sub_col_inc >= {1'b0, ustep};
    assign row_end        = block_col_inc >= {1'b0, out_cols};
    assign last_sub_row   = sub_row_inc >= {1'b0, vstep};
    assign last_block_row = block_row_inc >= {1'b0, out_rows};

    always_comb begin
        row_partial_next = row_partial_reg;
        sub_col_next     = sub_col_reg;
        sub_row_next     = sub_row_reg;
        block_col_next   = block_col_reg;
        block_row_next   = block_row_reg;
        if (restart) begin
            row_partial_next = '0;
            sub_col_next     = '0;
            sub_row_next     = '0;
            block_col_next   = '0;
            block_row_next   = '0;
        end else if (accept) begin
            if (!piece_done) begin
                row_partial_next = piece_sum;
                sub_col_next     = sub_col_inc[STEP_W-1:0];
            end else begin
                row_partial_next = '0;
                sub_col_next     = '0;
                if (!row_end) begin
                    block_col_next = block_col_inc[COL_W-1:0];
                end else begin
                    block_col_next = '0;
                    if (!last_sub_row) begin
                        sub_row_next = sub_row_inc[STEP_W-1:0];
                    end else begin
                        sub_row_next   = '0;
                        block_row_next = last_block_row ? '0 : block_row_inc[COL_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_partial_reg <= '0;
            sub_col_reg     <= '0;
            sub_row_reg     <= '0;
            block_col_reg   <= '0;
            block_row_reg   <= '0;
        end else begin
            row_partial_reg <= row_partial_next;
            sub_col_reg     <= sub_col_next;
            sub_row_reg     <= sub_row_next;
            block_col_reg   <= block_col_next;
            block_row_reg   <= block_row_next;
        end
    end

    assign push               = accept && piece_done && !restart;
    assign push_sum           = piece_sum;
    assign push_col           = block_col_reg[ADDR_W-1:0];
    assign push_ctl.first_row = (sub_row_reg == '0);
    assign push_ctl.emit      = last_sub_row;
    assign push_ctl.fin       = row_end && last_block_row;

endmodule

// ===== rtl/core/bavg_back.sv =====
module bavg_back #(
    parameter int PIXEL_BITS = 24,
    parameter int MAX_STEP   = 16,
    parameter int MAX_COLS   = 1024
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          q_empty,
    input  logic [PIXEL_BITS+$clog2(MAX_STEP)-1:0]        q_sum,
    input  logic [(MAX_COLS > 1 ? $clog2(MAX_COLS) : 1)-1:0] q_col,
    input  bavg_pkg::piece_ctl_t                          q_ctl,
    output logic                                          q_pop,
    input  logic [$clog2(MAX_STEP+1)-1:0]                 ustep,
    input  logic [$clog2(MAX_STEP+1)-1:0]                 vstep,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic [PIXEL_BITS-1:0]                         out_average,
    output logic                                          out_last,
    output bavg_pkg::back_status_t                        status
);

    localparam int STEP_W = $clog2(MAX_STEP + 1);
    localparam int ADDR_W = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;
    localparam int PW     = PIXEL_BITS + $clog2(MAX_STEP);
    localparam int SUM_W  = PIXEL_BITS + 2 * $clog2(MAX_STEP);
    localparam int D_W    = 2 * STEP_W;
    localparam int CNT_W  = $clog2(SUM_W);

    bavg_pkg::back_state_t state_reg, state_next;
    bavg_pkg::piece_ctl_t  ctl_reg;

    logic signed [PW-1:0]    part_reg;
    logic [ADDR_W-1:0]       col_reg;
    logic signed [SUM_W-1:0] acc_reg;
    logic                    neg_reg;
    logic [SUM_W-1:0]        mag_reg;
    logic [D_W-1:0]          rem_reg;
    logic [SUM_W-1:0]        quo_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [D_W-1:0]          div_reg;
    logic                    out_valid_reg;
    logic [PIXEL_BITS-1:0]   out_data_reg;
    logic                    out_last_reg;

    logic                    pop, ram_we, out_load, out_free;
    logic [SUM_W-1:0]        ram_rdata;
    logic signed [SUM_W-1:0] acc_new;
    logic [D_W:0]            rem_sh, trial;
    logic [PIXEL_BITS-1:0]   quo_low, result;

    bavg_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_COLS)
    ) u_col_sums (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (col_reg),
        .wdata (acc_new),
        .re    (pop),
        .raddr (q_col),
        .rdata (ram_rdata)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign acc_new  = ctl_reg.first_row ? SUM_W'(part_reg)
                                        : $signed(ram_rdata) + SUM_W'(part_reg);
    // one restoring step: bring down the next dividend bit
    assign rem_sh   = {rem_reg, mag_reg[SUM_W-1]};
    assign trial    = rem_sh - {1'b0, div_reg};
    assign quo_low  = quo_reg[PIXEL_BITS-1:0];
    assign result   = neg_reg ? -quo_low : quo_low;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bavg_pkg::BK_IDLE: if (!q_empty) state_next = bavg_pkg::BK_ACC;
            bavg_pkg::BK_ACC:  state_next = ctl_reg.emit ? bavg_pkg::BK_ABS
                                                         : bavg_pkg::BK_IDLE;
            bavg_pkg::BK_ABS:  state_next = bavg_pkg::BK_DIV;
            bavg_pkg::BK_DIV:  if (cnt_reg == CNT_W'(SUM_W - 1)) state_next = bavg_pkg::BK_OUT;
            bavg_pkg::BK_OUT:  if (out_free) state_next = bavg_pkg::BK_IDLE;
            default:           state_next = bavg_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        pop      = 1'b0;
        ram_we   = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            bavg_pkg::BK_IDLE: pop      = !q_empty;
            bavg_pkg::BK_ACC:  ram_we   = 1'b1;
            bavg_pkg::BK_OUT:  out_load = out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bavg_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            part_reg <= $signed(q_sum);
            col_reg  <= q_col;
            ctl_reg  <= q_ctl;
        end
        if (ram_we) begin
            acc_reg <= acc_new;
            div_reg <= D_W'(ustep) * D_W'(vstep);
        end
        if (state_reg == bavg_pkg::BK_ABS) begin
            neg_reg <= acc_reg[SUM_W-1];
            mag_reg <= acc_reg[SUM_W-1] ? -acc_reg : acc_reg;
            rem_reg <= '0;
            quo_reg <= '0;
            cnt_reg <= '0;
        end
        if (state_reg == bavg_pkg::BK_DIV) begin
            mag_reg <= {mag_reg[SUM_W-2:0], 1'b0};
            rem_reg <= trial[D_W] ? rem_sh[D_W-1:0] : trial[D_W-1:0];
            quo_reg <= {quo_reg[SUM_W-2:0], !trial[D_W]};
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (out_load) begin
            out_data_reg <= result;
            out_last_reg <= ctl_reg.fin;
        end
    end

    assign q_pop           = pop;
    assign out_valid       = out_valid_reg;
    assign out_average     = out_data_reg;
    assign out_last        = out_last_reg;
    assign status.pop      = pop;
    assign status.out_load = out_load;

endmodule

// ===== rtl/core/box_average_downsampler.sv =====
// Box average downsampler: averages each vstep x ustep block of a raster
// pixel stream into one output pixel (mean truncated toward zero).
// Input: s_tvalid/s_tready/s_tdata, one source pixel per transaction, raster
// order. Output: m_tvalid/m_tready/m_tdata, one mean per block in raster
// order, m_tlast on the final mean of the frame. Frames follow each other
// with no gap. Configure through cfg_we/cfg_index/cfg_wdata while idle; any
// write restarts the frame position.
// Flow: the input takes a pixel whenever the queue is not full. Each row
// piece passes through the column sum unit (read/accumulate of the column
// sum RAM); a piece that completes a block then goes through the sign
// removal, bit-serial divider and output load; the back end pops no new
// piece until it is done. A 4-entry queue lets the input keep taking
// pixels while the back end works. A mean reaches m_tvalid after its last
// row piece is queued, popped, accumulated, divided and loaded.
// Reset: registers return to 1, frame position to the start, queue and
// output empty. If m_tready is low the output register holds its mean, the
// back end waits, the queue fills and then s_tready drops.
`include "box_average_downsampler_macros.svh"

module box_average_downsampler #(
    parameter int PIXEL_BITS = 24,
    parameter int MAX_STEP   = 16,
    parameter int MAX_COLS   = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((PIXEL_BITS+7)/8)*8-1:0]     s_tdata,   // [PIXEL_BITS-1:0] pixel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((PIXEL_BITS+7)/8)*8-1:0]     m_tdata,   // [PIXEL_BITS-1:0] average
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic [bavg_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bavg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int TDATA_W     = ((PIXEL_BITS + 7) / 8) * 8;
    localparam int STEP_W      = $clog2(MAX_STEP + 1);
    localparam int COL_W       = $clog2(MAX_COLS + 1);
    localparam int ADDR_W      = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;
    localparam int PW          = PIXEL_BITS + $clog2(MAX_STEP);
    localparam int CTL_W       = $bits(bavg_pkg::piece_ctl_t);
    localparam int ENTRY_W     = PW + ADDR_W + CTL_W;
    localparam int QUEUE_DEPTH = 4;

    logic [STEP_W-1:0] ustep_reg, vstep_reg;
    logic [COL_W-1:0]  out_cols_reg, out_rows_reg;
    logic [STEP_W-1:0] step_clamped;
    logic [COL_W-1:0]  size_clamped;
    logic [bavg_pkg::STEP_FIELD_W-1:0] step_raw;

    logic                   q_push, q_pop, q_full, q_empty;
    logic [PW-1:0]          push_sum;
    logic [ADDR_W-1:0]      push_col;
    bavg_pkg::piece_ctl_t   push_ctl;
    logic [ENTRY_W-1:0]     q_head;
    bavg_pkg::back_status_t bk_status;
    logic [PIXEL_BITS-1:0]  average;

    // zero acts as one, oversize saturates
    assign step_raw = cfg_wdata[bavg_pkg::STEP_FIELD_W-1:0];
    always_comb begin
        priority if (step_raw == '0) begin
            step_clamped = STEP_W'(1);
        end else if (int'(step_raw) > MAX_STEP) begin
            step_clamped = STEP_W'(MAX_STEP);
        end else begin
            step_clamped = STEP_W'(step_raw);
        end
        priority if (cfg_wdata == '0) begin
            size_clamped = COL_W'(1);
        end else if (int'(cfg_wdata) > MAX_COLS) begin
            size_clamped = COL_W'(MAX_COLS);
        end else begin
            size_clamped = COL_W'(cfg_wdata);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ustep_reg    <= STEP_W'(1);
            vstep_reg    <= STEP_W'(1);
            out_cols_reg <= COL_W'(1);
            out_rows_reg <= COL_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_index)
                bavg_pkg::CFG_USTEP:    ustep_reg    <= step_clamped;
                bavg_pkg::CFG_VSTEP:    vstep_reg    <= step_clamped;
                bavg_pkg::CFG_OUT_COLS: out_cols_reg <= size_clamped;
                bavg_pkg::CFG_OUT_ROWS: out_rows_reg <= size_clamped;
                default: begin
                end
            endcase
        end
    end

    assign s_tready = !q_full;

    bavg_front #(
        .PIXEL_BITS (PIXEL_BITS),
        .MAX_STEP   (MAX_STEP),
        .MAX_COLS   (MAX_COLS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .restart  (cfg_we),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .pixel    (s_tdata[PIXEL_BITS-1:0]),
        .ustep    (ustep_reg),
        .vstep    (vstep_reg),
        .out_cols (out_cols_reg),
        .out_rows (out_rows_reg),
        .push     (q_push),
        .push_sum (push_sum),
        .push_col (push_col),
        .push_ctl (push_ctl)
    );

    bavg_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data ({push_ctl, push_col, push_sum}),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    bavg_back #(
        .PIXEL_BITS (PIXEL_BITS),
        .MAX_STEP   (MAX_STEP),
        .MAX_COLS   (MAX_COLS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_empty     (q_empty),
        .q_sum       (q_head[PW-1:0]),
        .q_col       (q_head[PW+ADDR_W-1:PW]),
        .q_ctl       (q_head[ENTRY_W-1:PW+ADDR_W]),
        .q_pop       (q_pop),
        .ustep       (ustep_reg),
        .vstep       (vstep_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_average (average),
        .out_last    (m_tlast),
        .status      (bk_status)
    );

    assign m_tdata = TDATA_W'(average);

    `BAVG_ASSERT_NEVER(a_push_when_full, aclk, aresetn, q_push && q_full, "row piece pushed into full queue")
    `BAVG_ASSERT_NEVER(a_pop_when_empty, aclk, aresetn, bk_status.pop && q_empty, "back end popped empty queue")
    `BAVG_ASSERT_IMP(a_valid_from_load, aclk, aresetn, $rose(m_tvalid), $past(bk_status.out_load), "output valid without a result load")

endmodule

// ===== test/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEP_LIMIT = 16;
    localparam int SIZE_LIMIT = 1024;
    localparam int STIM_ITEMS = 1650;
    localparam int DRAIN_CYCLES = 80;

    typedef struct {
        logic [23:0] average;
        logic        last;
    } mean_t;

    class mean_tracker;
        logic [4:0]  ustep;
        logic [4:0]  vstep;
        logic [10:0] out_cols;
        logic [10:0] out_rows;
        longint      col_sum [SIZE_LIMIT];
        longint      piece_sum;
        int          sub_col;
        int          block_col;
        int          sub_row;
        int          block_row;
        mean_t       pending_means [$];
        int          errors;

        function new();
            ustep = 5'd1;
            vstep = 5'd1;
            out_cols = 11'd1;
            out_rows = 11'd1;
            errors = 0;
            restart();
        endfunction

        function void restart();
            piece_sum = 0;
            sub_col = 0;
            block_col = 0;
            sub_row = 0;
            block_row = 0;
        endfunction

        function int step_eff(logic [4:0] v);
            if (v == 0) return 1;
            if (v > STEP_LIMIT) return STEP_LIMIT;
            return int'(v);
        endfunction

        function int size_eff(logic [10:0] v);
            if (v == 0) return 1;
            if (v > SIZE_LIMIT) return SIZE_LIMIT;
            return int'(v);
        endfunction

        // any register write drops the partly received frame
        function void set_reg(logic [bavg_pkg::CFG_INDEX_W-1:0] idx,
                              logic [bavg_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                bavg_pkg::CFG_USTEP: ustep = data[4:0];
                bavg_pkg::CFG_VSTEP: vstep = data[4:0];
                bavg_pkg::CFG_OUT_COLS: out_cols = data;
                bavg_pkg::CFG_OUT_ROWS: out_rows = data;
                default: ;
            endcase
            restart();
        endfunction

        function void take_pixel(logic [23:0] data);
            int    us;
            int    vs;
            int    nc;
            int    nr;
            mean_t m;
            us = step_eff(ustep);
            vs = step_eff(vstep);
            nc = size_eff(out_cols);
            nr = size_eff(out_rows);
            piece_sum += longint'($signed(data));
            sub_col++;
            if (sub_col < us) return;
            sub_col = 0;
            if (sub_row == 0) col_sum[block_col] = piece_sum;
            else col_sum[block_col] += piece_sum;
            piece_sum = 0;
            if (sub_row + 1 >= vs) begin
                // signed division truncates toward zero
                m.average = 24'(col_sum[block_col] / longint'(us * vs));
                m.last = (block_col + 1 >= nc) && (block_row + 1 >= nr);
                pending_means.insert(pending_means.size(), m);
            end
            block_col++;
            if (block_col >= nc) begin
                block_col = 0;
                sub_row++;
                if (sub_row >= vs) begin
                    sub_row = 0;
                    block_row++;
                    if (block_row >= nr) block_row = 0;
                end
            end
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_mean(logic [23:0] average, logic last);
            mean_t m;
            if (pending_means.size() == 0) begin
                report($sformatf("unexpected mean %h last %b", average, last));
                return;
            end
            m = pending_means.pop_front();
            if (average !== m.average)
                report($sformatf("average %h, expected %h", average, m.average));
            if (last !== m.last)
                report($sformatf("last %b, expected %b", last, m.last));
        endtask
    endclass

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [23:0]                      s_tdata = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [23:0]                      m_tdata;
    logic                             m_tlast;
    logic                             cfg_we = 1'b0;
    logic [bavg_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [bavg_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

    int          sender_idle_pct = 0;
    int          recv_stall_pct = 0;
    mean_tracker tracker;

    box_average_downsampler dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) tracker.take_pixel(s_tdata);
        if (aresetn && m_tvalid && m_tready) tracker.check_mean(m_tdata, m_tlast);
    end

    // called at a falling edge; returns right after the accepting rising edge
    task send_pixel(logic [23:0] value);
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= value;
        do @(posedge aclk); while (!s_tready);
    endtask

    task end_burst();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // wait for every pending mean, then let row pieces without a result finish
    task settle();
        while (tracker.pending_means.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task write_reg(logic [bavg_pkg::CFG_INDEX_W-1:0] idx,
                   logic [bavg_pkg::CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        tracker.set_reg(idx, data);
        @(negedge aclk);
    endtask

    task program_regs(logic [10:0] wu, logic [10:0] wv, logic [10:0] wc, logic [10:0] wr);
        write_reg(bavg_pkg::CFG_USTEP, wu);
        write_reg(bavg_pkg::CFG_VSTEP, wv);
        write_reg(bavg_pkg::CFG_OUT_COLS, wc);
        write_reg(bavg_pkg::CFG_OUT_ROWS, wr);
        cfg_we <= 1'b0;
    endtask

    function logic [23:0] pick_pixel();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 24'h7FFFFF;
        if (r == 1) return 24'h800000;
        return 24'($urandom);
    endfunction

    // mostly small steps, some zero, maximum and above-range values, junk upper bits
    function logic [10:0] pick_step();
        int         r;
        logic [4:0] v;
        r = $urandom_range(99);
        if (r < 55) v = 5'($urandom_range(1, 4));
        else if (r < 70) v = 5'($urandom_range(5, 15));
        else if (r < 80) v = 5'(STEP_LIMIT);
        else if (r < 88) v = 5'd0;
        else v = 5'($urandom_range(17, 31));
        if ($urandom_range(9) < 3) return {6'($urandom), v};
        return {6'd0, v};
    endfunction

    function logic [10:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 11'($urandom_range(1, 6));
        if (r < 75) return 11'($urandom_range(7, 40));
        if (r < 83) return 11'd0;
        if (r < 90) return 11'(SIZE_LIMIT);
        return 11'($urandom_range(1025, 2047));
    endfunction

    initial begin
        int          sent;
        int          n;
        int          frame;
        int          phase;
        logic [10:0] wu;
        logic [10:0] wv;
        logic [10:0] wc;
        logic [10:0] wr;

        tracker = new();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: every pixel is its own block and ends the frame
        send_pixel(24'h7FFFFF);
        send_pixel(24'h800000);
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        end_burst();
        settle();

        // partial frame, then a rewrite restarts the frame position
        program_regs(11'd2, 11'd2, 11'd2, 11'd1);
        repeat (3) send_pixel(24'h7FFFFF);
        end_burst();
        settle();
        program_regs(11'd2, 11'd2, 11'd2, 11'd1);
        repeat (4) send_pixel(24'h800000);
        repeat (4) send_pixel(pick_pixel());
        end_burst();

        sent = 0;
        phase = 0;
        while (sent < STIM_ITEMS) begin
            settle();
            case (phase % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin sender_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            wu = pick_step();
            wv = pick_step();
            wc = pick_size();
            wr = pick_size();
            program_regs(wu, wv, wc, wr);
            frame = tracker.step_eff(wu[4:0]) * tracker.step_eff(wv[4:0])
                  * tracker.size_eff(wc) * tracker.size_eff(wr);
            // whole frames where they are short, a broken tail now and then
            if (frame <= 600) begin
                n = frame * $urandom_range(1, 2);
                if ($urandom_range(3) == 0) n += $urandom_range(0, frame - 1);
            end else begin
                n = $urandom_range(40, 200);
            end
            if (n > STIM_ITEMS - sent) n = STIM_ITEMS - sent;
            repeat (n) send_pixel(pick_pixel());
            end_burst();
            sent += n;
            phase++;
        end

        settle();
        if (tracker.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
